### src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Wrappers for the concurrent checks at the end of the RTL module.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside of reset.
`define AST_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// When the antecedent holds, the consequent holds in the same cycle.
`define AST_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// When the antecedent holds, the consequent holds in the next cycle.
`define AST_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/tcw_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Text console cell writer package
// Command and result words, controller states and fixed character codes.
// ---------------------------------------------------------------------------
package tcw_pkg;

	typedef enum logic [1:0] {
		OP_PUT_CHAR   = 2'd0,
		OP_SET_CURSOR = 2'd1,
		OP_CLEAR      = 2'd2,
		OP_READ_CELL  = 2'd3
	} op_t;

	typedef struct packed {
		op_t        operation;
		logic [7:0] char_code;
		logic [6:0] column;
		logic [4:0] row;
	} command_t;

	typedef struct packed {
		logic [7:0] cell_char;
		logic [7:0] cell_attribute;
		logic [6:0] cursor_column;
		logic [4:0] cursor_row;
	} result_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_ADDR,
		ST_EXEC,
		ST_READ,
		ST_SWEEP
	} state_t;

	localparam logic [7:0] CHAR_NEWLINE = 8'd10;
	localparam logic [7:0] CHAR_TAB     = 8'd9;
	localparam logic [7:0] CHAR_BLANK   = 8'd32;
	localparam int         TAB_STOP     = 8;
	localparam int         TAB_W        = 3;
	localparam logic [7:0] ATTR_RESET   = 8'd7;

	localparam int         APB_ADDR_W   = 3;
	localparam int         APB_DATA_W   = 32;
	// Register index, taken from the word address bit of paddr.
	localparam logic       REG_DEFAULT_ATTR = 1'b0;

endpackage

### src/text_console_cell_writer.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// Text console cell writer
// Character and attribute grid with a linear print position, row scrolling
// through a rotating top-row offset, and an APB register for the attribute.
// ---------------------------------------------------------------------------
//
//  Channel   Handshake                        Payload
//  --------  -------------------------------  ------------------------------
//  command   start high while busy is low     command_t (op, char, col, row)
//  result    done high for one cycle          result_t (cell, cursor)
//  config    psel & penable & pwrite & pready default_attribute at byte 0
//
// Put character and set cursor keep busy high through the address and
// execute states; read cell adds a read state, and a new word is taken
// only once busy is low again. A put character that scrolls also blanks
// the COLUMNS cells of the new bottom row, and clear screen blanks all
// COLUMNS*ROWS cells, one memory write per cycle. After reset the block
// sweeps zeros through all cells before the first word is taken.
// The result receiver cannot stall: done marks a word valid for one cycle.
//
module text_console_cell_writer
	import tcw_pkg::*;
#(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Command channel
	input  logic                  start,
	output logic                  busy,
	input  command_t              command,
	// Result channel
	output logic                  done,
	output result_t               result,
	// Configuration port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int CELLS      = COLUMNS * ROWS;
	localparam int ADDR_W     = $clog2(CELLS);
	localparam int COL_W      = $clog2(COLUMNS);
	localparam int ROW_W      = $clog2(ROWS);
	localparam int LAST_START = CELLS - COLUMNS;
	// Wide enough to compare the command coordinates against sizes up to 511.
	localparam int CMP_W      = 9;

	// Screen memory: one word per cell, attribute in the upper byte. The
	// physical row of a logical row is (row + top_q) mod ROWS, so a scroll
	// only moves top_q and blanks one row.
	logic [15:0] mem [CELLS];
	logic [15:0] mem_rdata_q;
	logic        mem_we;
	logic        mem_re;
	logic [ADDR_W-1:0] mem_waddr;
	logic [15:0] mem_wdata;

	state_t state_q, state_d;

	// Cursor kept as column and row; the low bits of the linear position
	// are kept separately since tab stops follow the linear offset.
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [TAB_W-1:0]  phase_q;
	logic [ROW_W-1:0]  top_q;
	logic [ADDR_W-1:0] top_base_q;
	logic [7:0]        attr_q;
	logic [ADDR_W-1:0] sweep_addr_q;
	logic [ADDR_W-1:0] sweep_end_q;
	logic              done_q;
	logic [7:0]        cell_char_q;
	logic [7:0]        cell_attr_q;

	// Command word and address stage registers.
	command_t          cmd_q;
	logic [COL_W-1:0]  col_s1;
	logic [ROW_W-1:0]  row_s1;
	logic [ROW_W-1:0]  phys_row_s1;
	logic              in_range_s1;

	// Address stage logic.
	logic [CMP_W-1:0]  a_col_w;
	logic [CMP_W-1:0]  a_row_w;
	logic              a_col_over;
	logic              a_row_over;
	logic [COL_W-1:0]  a_col;
	logic [ROW_W-1:0]  a_row;
	logic [ROW_W:0]    a_phys_sum;
	logic [ROW_W-1:0]  a_phys;

	// Execute stage logic.
	logic [ADDR_W-1:0] exec_addr;
	logic [COL_W:0]    col_x;
	logic [COL_W:0]    col_sum;
	logic [TAB_W:0]    tab_step;
	logic              row_wrap;
	logic              row_last;
	logic              p_scroll;
	logic              p_write;
	logic [COL_W-1:0]  p_col;
	logic [ROW_W-1:0]  p_row;
	logic [TAB_W-1:0]  p_phase;
	logic [TAB_W-1:0]  set_phase;

	logic              sweep_end_hit;
	logic              done_d;
	logic [7:0]        cell_char_d;
	logic [7:0]        cell_attr_d;
	logic              cfg_write;
	logic              cfg_hit;

	// -----------------------------------------------------------------------
	// Config register. Writes must come only while idle; the block won't check.
	// -----------------------------------------------------------------------
	assign pready    = 1'b1;
	assign cfg_hit   = (paddr[APB_ADDR_W-1:2] == REG_DEFAULT_ATTR);
	assign cfg_write = psel && penable && pwrite && pready && cfg_hit;
	assign prdata    = cfg_hit ? {{(APB_DATA_W-8){1'b0}}, attr_q} : '0;

	// -----------------------------------------------------------------------
	// Address stage: pick the coordinates (cursor or command), saturate them
	// for set cursor and rotate the row into its physical place.
	// -----------------------------------------------------------------------
	always_comb begin
		a_col_w    = CMP_W'(cmd_q.column);
		a_row_w    = CMP_W'(cmd_q.row);
		a_col_over = (a_col_w >= CMP_W'(COLUMNS));
		a_row_over = (a_row_w >= CMP_W'(ROWS));
		case (cmd_q.operation)
			OP_SET_CURSOR: begin
				a_col = a_col_over ? COL_W'(COLUMNS - 1) : COL_W'(a_col_w);
				a_row = a_row_over ? ROW_W'(ROWS - 1) : ROW_W'(a_row_w);
			end
			OP_READ_CELL: begin
				a_col = COL_W'(a_col_w);
				a_row = ROW_W'(a_row_w);
			end
			default: begin
				a_col = col_q;
				a_row = row_q;
			end
		endcase
		a_phys_sum = {1'b0, a_row} + {1'b0, top_q};
		if (a_phys_sum >= (ROW_W+1)'(ROWS)) begin
			a_phys = ROW_W'(a_phys_sum - (ROW_W+1)'(ROWS));
		end else begin
			a_phys = ROW_W'(a_phys_sum);
		end
	end

	// -----------------------------------------------------------------------
	// Execute stage: cell address and the cursor after put character.
	// -----------------------------------------------------------------------
	always_comb begin
		exec_addr = ADDR_W'(32'(phys_row_s1) * 32'(COLUMNS)) + ADDR_W'(col_s1);
		set_phase = TAB_W'(32'(row_s1) * 32'(COLUMNS)) + TAB_W'(col_s1);
		col_x     = {1'b0, col_q};
		tab_step  = (TAB_W+1)'(TAB_STOP) - {1'b0, phase_q};
		row_last  = (row_q == ROW_W'(ROWS - 1));
		p_write   = 1'b0;
		col_sum   = '0;
		row_wrap  = 1'b0;
		p_col     = col_q;
		p_phase   = phase_q;
		case (cmd_q.char_code)
			CHAR_NEWLINE: begin
				row_wrap = 1'b1;
				p_col    = '0;
				p_phase  = phase_q + TAB_W'((COL_W+1)'(COLUMNS) - col_x);
			end
			CHAR_TAB: begin
				// The step never exceeds one row, so the column wraps at most once.
				col_sum = col_x + (COL_W+1)'(tab_step);
				p_phase = '0;
				if (col_sum >= (COL_W+1)'(COLUMNS)) begin
					row_wrap = 1'b1;
					p_col    = COL_W'(col_sum - (COL_W+1)'(COLUMNS));
				end else begin
					p_col    = COL_W'(col_sum);
				end
			end
			default: begin
				p_write = 1'b1;
				col_sum = col_x + (COL_W+1)'(1);
				p_phase = phase_q + TAB_W'(1);
				if (col_sum == (COL_W+1)'(COLUMNS)) begin
					row_wrap = 1'b1;
					p_col    = '0;
				end else begin
					p_col    = COL_W'(col_sum);
				end
			end
		endcase
		// Leaving the last row scrolls and parks at the start of that row.
		p_scroll = row_wrap && row_last;
		if (p_scroll) begin
			p_col   = '0;
			p_row   = row_q;
			p_phase = TAB_W'(LAST_START);
		end else begin
			p_row   = row_wrap ? row_q + ROW_W'(1) : row_q;
		end
	end

	assign sweep_end_hit = (sweep_addr_q == sweep_end_q);

	// -----------------------------------------------------------------------
	// Next state.
	// -----------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (sweep_end_hit) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					state_d = ST_ADDR;
				end
			end
			ST_ADDR: begin
				state_d = ST_EXEC;
			end
			ST_EXEC: begin
				case (cmd_q.operation)
					OP_PUT_CHAR:  state_d = p_scroll ? ST_SWEEP : ST_IDLE;
					OP_CLEAR:     state_d = ST_SWEEP;
					OP_READ_CELL: state_d = ST_READ;
					default:      state_d = ST_IDLE;
				endcase
			end
			ST_READ: begin
				state_d = ST_IDLE;
			end
			ST_SWEEP: begin
				if (sweep_end_hit) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_INIT;
			end
		endcase
	end

	// -----------------------------------------------------------------------
	// Outputs: memory strobes, result strobe and result cell.
	// -----------------------------------------------------------------------
	always_comb begin
		busy        = (state_q != ST_IDLE);
		mem_we      = 1'b0;
		mem_re      = 1'b0;
		mem_waddr   = sweep_addr_q;
		mem_wdata   = '0;
		done_d      = 1'b0;
		cell_char_d = '0;
		cell_attr_d = '0;
		case (state_q)
			ST_INIT: begin
				mem_we = 1'b1;
			end
			ST_EXEC: begin
				case (cmd_q.operation)
					OP_PUT_CHAR: begin
						mem_we    = p_write;
						mem_waddr = exec_addr;
						mem_wdata = {attr_q, cmd_q.char_code};
						done_d    = !p_scroll;
					end
					OP_SET_CURSOR: begin
						done_d = 1'b1;
					end
					OP_READ_CELL: begin
						mem_re = in_range_s1;
					end
					default: begin
						done_d = 1'b0;
					end
				endcase
			end
			ST_READ: begin
				done_d = 1'b1;
				if (in_range_s1) begin
					cell_char_d = mem_rdata_q[7:0];
					cell_attr_d = mem_rdata_q[15:8];
				end
			end
			ST_SWEEP: begin
				mem_we    = 1'b1;
				mem_wdata = {attr_q, CHAR_BLANK};
				done_d    = sweep_end_hit;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// -----------------------------------------------------------------------
	// Screen memory.
	// -----------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			mem_rdata_q <= mem[exec_addr];
		end
	end

	// -----------------------------------------------------------------------
	// Control registers.
	// -----------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_INIT;
			col_q        <= '0;
			row_q        <= '0;
			phase_q      <= '0;
			top_q        <= '0;
			top_base_q   <= '0;
			attr_q       <= ATTR_RESET;
			sweep_addr_q <= '0;
			sweep_end_q  <= ADDR_W'(CELLS - 1);
			done_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
			if (cfg_write) begin
				attr_q <= pwdata[7:0];
			end
			if ((state_q == ST_INIT || state_q == ST_SWEEP) && !sweep_end_hit) begin
				sweep_addr_q <= sweep_addr_q + ADDR_W'(1);
			end
			if (state_q == ST_EXEC) begin
				case (cmd_q.operation)
					OP_PUT_CHAR: begin
						col_q   <= p_col;
						row_q   <= p_row;
						phase_q <= p_phase;
						if (p_scroll) begin
							// The old top row becomes the new bottom row.
							sweep_addr_q <= top_base_q;
							sweep_end_q  <= top_base_q + ADDR_W'(COLUMNS - 1);
							if (top_q == ROW_W'(ROWS - 1)) begin
								top_q      <= '0;
								top_base_q <= '0;
							end else begin
								top_q      <= top_q + ROW_W'(1);
								top_base_q <= top_base_q + ADDR_W'(COLUMNS);
							end
						end
					end
					OP_SET_CURSOR: begin
						col_q   <= col_s1;
						row_q   <= row_s1;
						phase_q <= set_phase;
					end
					OP_CLEAR: begin
						col_q        <= '0;
						row_q        <= '0;
						phase_q      <= '0;
						top_q        <= '0;
						top_base_q   <= '0;
						sweep_addr_q <= '0;
						sweep_end_q  <= ADDR_W'(CELLS - 1);
					end
					default: begin
						col_q <= col_q;
					end
				endcase
			end
		end
	end

	// -----------------------------------------------------------------------
	// Payload registers: command word, address stage and result cell.
	// -----------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			cmd_q <= command;
		end
		if (state_q == ST_ADDR) begin
			col_s1      <= a_col;
			row_s1      <= a_row;
			phys_row_s1 <= a_phys;
			in_range_s1 <= !a_col_over && !a_row_over;
		end
		if (done_d) begin
			cell_char_q <= cell_char_d;
			cell_attr_q <= cell_attr_d;
		end
	end

	// The cursor registers are updated no later than the edge that raises done,
	// so the result word shows the cursor after the step.
	always_comb begin
		result.cell_char      = cell_char_q;
		result.cell_attribute = cell_attr_q;
		result.cursor_column  = 7'(col_q);
		result.cursor_row     = 5'(row_q);
	end

	assign done = done_q;

	// -----------------------------------------------------------------------
	// Assertions.
	// -----------------------------------------------------------------------
	`AST_IMPLY(a_done_when_idle, done_q, state_q == ST_IDLE, "result strobe outside idle")
	`AST_NEXT(a_no_early_result, start && !busy, !done_q, "result right after accept")
	`AST_ALWAYS(a_cursor_range, ({1'b0, col_q} < (COL_W+1)'(COLUMNS)) && ({1'b0, row_q} < (ROW_W+1)'(ROWS)), "cursor out of grid")
	`AST_ALWAYS(a_top_base, top_base_q == ADDR_W'(32'(top_q) * 32'(COLUMNS)), "top row base mismatch")

endmodule

### tb/sv/tcw_result_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Text console result checker
// Watches the command, result and register channels of the console, keeps a
// shadow copy of the grid, the print position and the attribute register,
// and compares every result word with the one the shadow predicts.
// ---------------------------------------------------------------------------
module tcw_result_checker
	import tcw_pkg::*;
#(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  busy,
	input  command_t              command,
	input  logic                  done,
	input  result_t               result,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	input  logic                  pready,
	output int                    failures,
	output int                    pending,
	output int                    scrolls
);

	localparam int unsigned CELLS    = COLUMNS * ROWS;
	localparam int unsigned LAST_ROW = CELLS - COLUMNS;

	logic [7:0]  shadow_char [CELLS];
	logic [7:0]  shadow_attr [CELLS];
	int unsigned print_pos;
	logic [7:0]  attr_setting;
	result_t     expected_q [$];

	function automatic void blank_cells(int unsigned from, int unsigned upto);
		for (int unsigned i = from; i < upto && i < CELLS; i++) begin
			shadow_char[i] = CHAR_BLANK;
			shadow_attr[i] = attr_setting;
		end
	endfunction

	function automatic void print_byte(logic [7:0] code);
		int unsigned pos;
		pos = (print_pos >= CELLS) ? CELLS - 1 : print_pos;
		if (code == CHAR_NEWLINE) begin
			pos += COLUMNS - (pos % COLUMNS);
		end else if (code == CHAR_TAB) begin
			pos += TAB_STOP - (pos % TAB_STOP);
		end else begin
			shadow_char[pos] = code;
			shadow_attr[pos] = attr_setting;
			pos++;
		end
		// Running off the last cell scrolls the grid up by one row.
		if (pos >= CELLS) begin
			for (int unsigned i = 0; i < LAST_ROW; i++) begin
				shadow_char[i] = shadow_char[i + COLUMNS];
				shadow_attr[i] = shadow_attr[i + COLUMNS];
			end
			blank_cells(LAST_ROW, CELLS);
			pos = LAST_ROW;
			scrolls++;
		end
		print_pos = pos;
	endfunction

	function automatic result_t console_step(command_t cmd);
		result_t     r;
		int unsigned col;
		int unsigned row;
		r   = '0;
		col = 32'(cmd.column);
		row = 32'(cmd.row);
		case (cmd.operation)
			OP_PUT_CHAR: begin
				print_byte(cmd.char_code);
			end
			OP_SET_CURSOR: begin
				if (col >= COLUMNS) col = COLUMNS - 1;
				if (row >= ROWS) row = ROWS - 1;
				print_pos = row * COLUMNS + col;
			end
			OP_CLEAR: begin
				blank_cells(0, CELLS);
				print_pos = 0;
			end
			default: begin
				if (col < COLUMNS && row < ROWS) begin
					r.cell_char      = shadow_char[row * COLUMNS + col];
					r.cell_attribute = shadow_attr[row * COLUMNS + col];
				end
			end
		endcase
		r.cursor_column = 7'(print_pos % COLUMNS);
		r.cursor_row    = 5'(print_pos / COLUMNS);
		return r;
	endfunction

	function automatic void compare_word(result_t got, result_t want);
		if (got.cell_char !== want.cell_char) begin
			$error("cell_char: expected %0d, actual %0d", want.cell_char, got.cell_char);
			failures++;
		end
		if (got.cell_attribute !== want.cell_attribute) begin
			$error("cell_attribute: expected %0d, actual %0d",
				want.cell_attribute, got.cell_attribute);
			failures++;
		end
		if (got.cursor_column !== want.cursor_column) begin
			$error("cursor_column: expected %0d, actual %0d",
				want.cursor_column, got.cursor_column);
			failures++;
		end
		if (got.cursor_row !== want.cursor_row) begin
			$error("cursor_row: expected %0d, actual %0d", want.cursor_row, got.cursor_row);
			failures++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int unsigned i = 0; i < CELLS; i++) begin
				shadow_char[i] = '0;
				shadow_attr[i] = '0;
			end
			print_pos    = 0;
			attr_setting = ATTR_RESET;
			expected_q.delete();
			failures = 0;
			pending  = 0;
			scrolls  = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr[APB_ADDR_W-1] == REG_DEFAULT_ATTR)
				attr_setting = pwdata[7:0];
			if (start && !busy)
				expected_q.push_back(console_step(command));
			if (done) begin
				if (expected_q.size() == 0) begin
					$error("result word with no command waiting for it");
					failures++;
				end else begin
					compare_word(result, expected_q.pop_front());
				end
			end
			pending = expected_q.size();
		end
	end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Text console cell writer testbench
// Drives command words in random bursts, reprograms the attribute register
// between phases and leaves all prediction and comparison to the checker.
// ---------------------------------------------------------------------------
module tb_top
	import tcw_pkg::*;
();

	localparam int COLUMNS      = 80;
	localparam int ROWS         = 25;
	localparam int RANDOM_WORDS = 1950;
	localparam int PHASES       = 6;
	// The longest quiet stretch of a healthy run is the clearing sweep after
	// reset or a clear screen, plus a sender gap; allow several times that.
	localparam int QUIET_LIMIT  = 4 * (COLUMNS * ROWS + COLUMNS + 64);

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	command_t              command;
	logic                  done;
	result_t               result;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	int failures;
	int pending;
	int scrolls;
	int words_sent;
	int clears_sent;
	int attr_writes;
	int quiet_cycles;

	text_console_cell_writer #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.command (command),
		.done    (done),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// The checker sits beside the block and sees exactly what the block sees.
	tcw_result_checker #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.command  (command),
		.done     (done),
		.result   (result),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.pready   (pready),
		.failures (failures),
		.pending  (pending),
		.scrolls  (scrolls)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Watchdog: any accepted command word, result word or register write
	// counts as progress. A block that hangs trips it.
	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else begin
			if ((start && !busy) || done || (psel && penable && pwrite && pready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Watchdog: no progress for %0d cycles", quiet_cycles);
				$display("FAIL text_console_cell_writer");
				$finish;
			end
		end
	end

	function automatic command_t make_word(op_t op, logic [7:0] code,
			logic [6:0] col, logic [4:0] row);
		command_t w;
		w.operation = op;
		w.char_code = code;
		w.column    = col;
		w.row       = row;
		return w;
	endfunction

	// Printable text with the odd tab or newline, as a program writing lines
	// to the console would produce.
	function automatic logic [7:0] text_byte();
		int pick;
		pick = $urandom_range(19);
		if (pick == 0) return CHAR_NEWLINE;
		if (pick == 1) return CHAR_TAB;
		return 8'($urandom_range(126, 32));
	endfunction

	// A free-form word. Fields the operation does not use are left random so
	// that every bit of every field toggles; coordinates lean toward the
	// bottom rows, where printing and scrolling happen.
	function automatic command_t random_word();
		command_t w;
		int       pick;
		w.operation = op_t'($urandom_range(3));
		w.char_code = 8'($urandom_range(255));
		w.column    = 7'($urandom_range(127));
		w.row       = 5'($urandom_range(31));
		pick        = $urandom_range(99);
		if (pick < 45) begin
			w.operation = OP_PUT_CHAR;
			case ($urandom_range(9))
				0:       w.char_code = CHAR_NEWLINE;
				1:       w.char_code = CHAR_TAB;
				default: ;
			endcase
		end else if (pick < 57) begin
			w.operation = OP_SET_CURSOR;
		end else if (pick < 59) begin
			w.operation = OP_CLEAR;
		end else begin
			w.operation = OP_READ_CELL;
		end
		// Most cursor moves and reads stay on the grid; the rest cover the
		// out-of-range saturation and zero-read cases.
		if (w.operation inside {OP_SET_CURSOR, OP_READ_CELL} && $urandom_range(9) != 0) begin
			w.column = 7'($urandom_range(COLUMNS - 1));
			w.row    = $urandom_range(1) ? 5'($urandom_range(ROWS - 1, ROWS - 3))
				: 5'($urandom_range(ROWS - 1));
		end
		return w;
	endfunction

	// Present one word and hold it until the block takes it. start is left
	// high so that a following word can go out back to back.
	task automatic send_word(command_t w);
		start   <= 1'b1;
		command <= w;
		do @(posedge clk); while (busy);
		words_sent++;
		if (w.operation == OP_CLEAR) clears_sent++;
	endtask

	task automatic pause(int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// The attribute register is only rewritten while the block is idle and
	// every result word has come back. The first edge lets busy and the
	// checker's count catch up with a word accepted just before.
	task automatic write_attribute(logic [7:0] value);
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0 || busy) @(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_DEFAULT_ATTR, 2'b00};
		pwdata  <= ($urandom() & 32'hFFFF_FF00) | APB_DATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		attr_writes++;
	endtask

	// Bursts are either free-form words or a line of text that starts near
	// the bottom of the grid, so scrolling is reached often. Between bursts
	// the sender idles for a random number of cycles, sometimes none.
	task automatic random_phase(int count);
		int sent;
		int len;
		int gap;
		bit text_run;
		sent = 0;
		while (sent < count) begin
			len      = ($urandom_range(3) == 0) ? $urandom_range(100, 40) : $urandom_range(20, 1);
			text_run = ($urandom_range(2) == 0);
			for (int k = 0; k < len && sent < count; k++) begin
				if (text_run && k == 0)
					send_word(make_word(OP_SET_CURSOR, 8'($urandom_range(255)),
						7'($urandom_range(COLUMNS - 1)),
						5'($urandom_range(ROWS - 1, ROWS - 2))));
				else if (text_run)
					send_word(make_word(OP_PUT_CHAR, text_byte(),
						7'($urandom_range(127)), 5'($urandom_range(31))));
				else
					send_word(random_word());
				sent++;
			end
			gap = $urandom_range(12);
			if (gap != 0) pause(gap);
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		start        = 1'b0;
		command      = '0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		words_sent   = 0;
		clears_sent  = 0;
		attr_writes  = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words under the reset attribute. A read of an untouched
		// cell sees zeros; byte zero and 0xFF print like any other byte.
		send_word(make_word(OP_READ_CELL, 8'h00, 7'd0, 5'd0));
		send_word(make_word(OP_PUT_CHAR, 8'h41, 7'd0, 5'd0));
		send_word(make_word(OP_PUT_CHAR, 8'h00, 7'd127, 5'd31));
		send_word(make_word(OP_PUT_CHAR, 8'hFF, 7'd0, 5'd0));
		send_word(make_word(OP_PUT_CHAR, CHAR_TAB, 7'd0, 5'd0));
		send_word(make_word(OP_PUT_CHAR, CHAR_NEWLINE, 7'd0, 5'd0));
		send_word(make_word(OP_READ_CELL, 8'hFF, 7'd0, 5'd0));
		send_word(make_word(OP_READ_CELL, 8'h00, 7'd2, 5'd0));
		send_word(make_word(OP_READ_CELL, 8'h00, 7'd3, 5'd0));
		// A cursor far off the grid saturates to the last cell, and a byte
		// printed there scrolls the grid.
		send_word(make_word(OP_SET_CURSOR, 8'h00, 7'd127, 5'd31));
		send_word(make_word(OP_PUT_CHAR, 8'h5A, 7'd0, 5'd0));
		send_word(make_word(OP_READ_CELL, 8'h00, 7'(COLUMNS - 1), 5'(ROWS - 2)));
		send_word(make_word(OP_READ_CELL, 8'h00, 7'd0, 5'(ROWS - 1)));
		// Newline on the bottom row, and a tab that lands exactly on the end.
		send_word(make_word(OP_SET_CURSOR, 8'h00, 7'(COLUMNS - 1), 5'(ROWS - 1)));
		send_word(make_word(OP_PUT_CHAR, CHAR_NEWLINE, 7'd0, 5'd0));
		send_word(make_word(OP_SET_CURSOR, 8'h00, 7'(COLUMNS - 4), 5'(ROWS - 1)));
		send_word(make_word(OP_PUT_CHAR, CHAR_TAB, 7'd0, 5'd0));
		// Reads off the grid return zeros and leave the cursor alone.
		send_word(make_word(OP_READ_CELL, 8'h00, 7'(COLUMNS), 5'd0));
		send_word(make_word(OP_READ_CELL, 8'h00, 7'd0, 5'(ROWS)));
		send_word(make_word(OP_READ_CELL, 8'hFF, 7'd127, 5'd31));
		send_word(make_word(OP_READ_CELL, 8'h00, 7'd0, 5'd0));
		send_word(make_word(OP_CLEAR, 8'hFF, 7'd127, 5'd31));
		send_word(make_word(OP_READ_CELL, 8'h00, 7'd5, 5'd5));
		send_word(make_word(OP_SET_CURSOR, 8'h00, 7'(COLUMNS - 1), 5'd0));
		send_word(make_word(OP_PUT_CHAR, 8'h7E, 7'd0, 5'd0));

		// Random phases, each under its own attribute: both extremes first,
		// then random values.
		for (int phase = 0; phase < PHASES; phase++) begin
			if (phase == 0)
				write_attribute(8'h00);
			else if (phase == 1)
				write_attribute(8'hFF);
			else
				write_attribute(8'($urandom_range(255)));
			random_phase(RANDOM_WORDS / PHASES);
		end

		// Drain: every expected word back, then a quiet margin in which any
		// stray result word would still be caught.
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (2 * COLUMNS) @(posedge clk);

		$display("Covered %0d command words with %0d clears and %0d scrolls under %0d attribute settings",
			words_sent, clears_sent, scrolls, attr_writes + 1);
		if (failures == 0) begin
			$display("PASS text_console_cell_writer");
		end else begin
			$display("%0d field mismatches", failures);
			$display("FAIL text_console_cell_writer");
		end
		$finish;
	end

endmodule

### files.f
+incdir+src
src/tcw_pkg.sv
src/text_console_cell_writer.sv
tb/sv/tcw_result_checker.sv
tb/sv/tb_top.sv
